FILE: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types, constants, keymap and microcode for the scancode line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int SC_W   = 8;
  localparam int CH_W   = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 6;
  localparam int STEP_W = 4;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  localparam logic [CH_W-1:0] KEY_NONE  = 8'd0;
  localparam logic [CH_W-1:0] KEY_BS    = 8'd8;
  localparam logic [CH_W-1:0] KEY_TAB   = 8'd9;
  localparam logic [CH_W-1:0] KEY_ENTER = 8'd10;
  localparam logic [CH_W-1:0] KEY_SHIFT = 8'd15;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [CH_W-1:0] CH_TILDE  = 8'd126;

  // microprogram addresses
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_DISP  = 4'd1;
  localparam logic [STEP_W-1:0] ST_TAB0  = 4'd2;
  localparam logic [STEP_W-1:0] ST_TAB1  = 4'd3;
  localparam logic [STEP_W-1:0] ST_TAB2  = 4'd4;
  localparam logic [STEP_W-1:0] ST_TAB3  = 4'd5;
  localparam logic [STEP_W-1:0] ST_BS0   = 4'd6;
  localparam logic [STEP_W-1:0] ST_BS1   = 4'd7;
  localparam logic [STEP_W-1:0] ST_BS2   = 4'd8;
  localparam logic [STEP_W-1:0] ST_ECHO  = 4'd9;
  localparam logic [STEP_W-1:0] ST_LINE  = 4'd10;
  localparam logic [STEP_W-1:0] ST_LCHAR = 4'd11;
  localparam logic [STEP_W-1:0] ST_LEND  = 4'd12;

  typedef enum logic [2:0] {
    CS_SPACE, CS_BS, CS_KEY, CS_STORE, CS_ZERO
  } csel_t;

  typedef enum logic [1:0] {
    LS_NO, LS_YES, LS_NOT_DONE
  } lsel_t;

  typedef enum logic [2:0] {
    SQ_NEXT, SQ_JUMP, SQ_WAIT_IN, SQ_DISPATCH, SQ_IF_DONE, SQ_IF_EMPTY, SQ_LOOP_LINE
  } seq_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_CLR_PTR, ACT_STORE, ACT_DEC, ACT_NEXT_CHAR, ACT_LINE_END
  } act_t;

  typedef struct packed {
    logic              emit;
    logic [KIND_W-1:0] kind;
    csel_t             csel;
    lsel_t             lsel;
    seq_t              seq;
    act_t              act;
    logic [STEP_W-1:0] target;
  } uword_t;

  localparam logic [CH_W-1:0] KEYMAP [0:127] = '{
    8'd0,   8'd27,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
    8'd57,  8'd48,  8'd45,  8'd61,  8'd8,   8'd9,   8'd113, 8'd119, 8'd101, 8'd114,
    8'd116, 8'd121, 8'd117, 8'd105, 8'd111, 8'd112, 8'd91,  8'd93,  8'd10,  8'd0,
    8'd97,  8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd59,
    8'd39,  8'd96,  8'd15,  8'd92,  8'd122, 8'd120, 8'd99,  8'd118, 8'd98,  8'd110,
    8'd109, 8'd44,  8'd46,  8'd47,  8'd15,  8'd42,  8'd16,  8'd32,  8'd17,  8'd1,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd29,
    8'd30,  8'd13,  8'd14,  8'd15,  8'd45,  8'd18,  8'd19,  8'd20,  8'd43,  8'd21,
    8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd11,  8'd12,  8'd31,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      ST_IDLE:  w = uword_t'{1'b0, KIND_ECHO, CS_ZERO,  LS_NO,  SQ_WAIT_IN,
                             ACT_NONE, ST_IDLE};
      ST_DISP:  w = uword_t'{1'b0, KIND_ECHO, CS_ZERO,  LS_NO,  SQ_DISPATCH,
                             ACT_CLR_PTR, ST_IDLE};
      ST_TAB0:  w = uword_t'{1'b1, KIND_ECHO, CS_SPACE, LS_NO,  SQ_NEXT,
                             ACT_NONE, ST_IDLE};
      ST_TAB1:  w = uword_t'{1'b1, KIND_ECHO, CS_SPACE, LS_NO,  SQ_NEXT,
                             ACT_NONE, ST_IDLE};
      ST_TAB2:  w = uword_t'{1'b1, KIND_ECHO, CS_SPACE, LS_NO,  SQ_NEXT,
                             ACT_NONE, ST_IDLE};
      ST_TAB3:  w = uword_t'{1'b1, KIND_ECHO, CS_SPACE, LS_YES, SQ_JUMP,
                             ACT_NONE, ST_IDLE};
      ST_BS0:   w = uword_t'{1'b1, KIND_ECHO, CS_BS,    LS_NO,  SQ_NEXT,
                             ACT_NONE, ST_IDLE};
      ST_BS1:   w = uword_t'{1'b1, KIND_ECHO, CS_SPACE, LS_NO,  SQ_NEXT,
                             ACT_NONE, ST_IDLE};
      ST_BS2:   w = uword_t'{1'b1, KIND_ECHO, CS_BS,    LS_YES, SQ_JUMP,
                             ACT_DEC, ST_IDLE};
      ST_ECHO:  w = uword_t'{1'b1, KIND_ECHO, CS_KEY,   LS_NOT_DONE, SQ_IF_DONE,
                             ACT_STORE, ST_IDLE};
      ST_LINE:  w = uword_t'{1'b0, KIND_ECHO, CS_ZERO,  LS_NO,  SQ_IF_EMPTY,
                             ACT_NONE, ST_LEND};
      ST_LCHAR: w = uword_t'{1'b1, KIND_CHAR, CS_STORE, LS_NO,  SQ_LOOP_LINE,
                             ACT_NEXT_CHAR, ST_IDLE};
      ST_LEND:  w = uword_t'{1'b1, KIND_END,  CS_ZERO,  LS_YES, SQ_JUMP,
                             ACT_LINE_END, ST_IDLE};
      default:  w = uword_t'{1'b0, KIND_ECHO, CS_ZERO,  LS_NO,  SQ_JUMP,
                             ACT_NONE, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/scancode_line_editor.sv
// ----------------------------------------------------------------------------
// scancode_line_editor
// Set-1 scancode to ascii line editor with echo, run by a microcode sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | scancode
//  out     | output    | out_valid/out_stall | kind, char_value, line_length, last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (line_limit)
//
//  one microcode step per cycle; a step that emits a beat waits while the
//  output register is full and stalled
//  per key: idle, dispatch, then echo, four spaces, bs-space-bs or nothing;
//  line emission: one stored character per cycle while unstalled, then end
//  reset clears sequencer and count, sets line_limit to 32; no memory sweep
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_line_editor #(
  parameter int LINE_MAX = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [sle_pkg::SC_W-1:0]   scancode,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [sle_pkg::KIND_W-1:0] kind,
  output logic      [sle_pkg::CH_W-1:0]   char_value,
  output logic      [sle_pkg::LEN_W-1:0]  line_length,
  output logic                            last,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [sle_pkg::LEN_W-1:0]  cfg_data
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(LINE_MAX + 1);
  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  logic [STEP_W-1:0] step, step_next;
  logic [CH_W-1:0]   key;
  logic [CNT_W-1:0]  count, ptr, ptr_next, new_count;
  logic [LEN_W-1:0]  line_limit, lim;
  logic [CH_W-1:0]   rdata, ch_sel;
  uword_t            uw;
  logic              in_fire, out_free, go, printable, can_store, done, last_sel;

  assign uw        = ucode(step);
  assign in_stall  = (step != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign go        = !uw.emit || out_free;

  // limit saturated to 1..LINE_MAX
  always_comb begin
    if (line_limit == '0) begin
      lim = LEN_W'(1);
    end else if (line_limit > LEN_W'(LINE_MAX)) begin
      lim = LEN_W'(LINE_MAX);
    end else begin
      lim = line_limit;
    end
  end

  assign printable = (key >= CH_SPACE) && (key <= CH_TILDE);
  assign can_store = printable && (count < CNT_W'(LINE_MAX));
  assign new_count = count + CNT_W'(can_store);
  assign done      = (key == KEY_ENTER) || (printable && (LEN_W'(new_count) >= lim));

  always_comb begin
    step_next = step;
    unique case (uw.seq)
      SQ_NEXT:     step_next = step + STEP_W'(1);
      SQ_JUMP:     step_next = uw.target;
      SQ_WAIT_IN:  step_next = in_fire ? ST_DISP : ST_IDLE;
      SQ_DISPATCH: begin
        if (key == KEY_NONE || key == KEY_SHIFT) begin
          step_next = ST_IDLE;
        end else if (key == KEY_TAB) begin
          step_next = (count != '0) ? ST_TAB0 : ST_IDLE;
        end else if (key == KEY_BS) begin
          step_next = (count != '0) ? ST_BS0 : ST_IDLE;
        end else begin
          step_next = ST_ECHO;
        end
      end
      SQ_IF_DONE:   step_next = done ? step + STEP_W'(1) : uw.target;
      SQ_IF_EMPTY:  step_next = (count == '0) ? uw.target : step + STEP_W'(1);
      SQ_LOOP_LINE: step_next = (ptr + CNT_W'(1) == count) ? step + STEP_W'(1) : step;
      default:      step_next = ST_IDLE;
    endcase
    if (!go) begin
      step_next = step;
    end
  end

  always_comb begin
    ptr_next = ptr;
    if (go && uw.act == ACT_CLR_PTR) begin
      ptr_next = '0;
    end else if (go && uw.act == ACT_NEXT_CHAR) begin
      ptr_next = ptr + CNT_W'(1);
    end
  end

  always_comb begin
    case (uw.csel)
      CS_SPACE: ch_sel = CH_SPACE;
      CS_BS:    ch_sel = KEY_BS;
      CS_KEY:   ch_sel = key;
      CS_STORE: ch_sel = rdata;
      default:  ch_sel = '0;
    endcase
  end

  always_comb begin
    case (uw.lsel)
      LS_YES:      last_sel = 1'b1;
      LS_NOT_DONE: last_sel = !done;
      default:     last_sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= ST_IDLE;
      count      <= '0;
      line_limit <= LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_valid && cfg_ready) begin
        line_limit <= cfg_data;
      end
      if (go) begin
        case (uw.act)
          ACT_STORE:    count <= new_count;
          ACT_DEC:      count <= count - CNT_W'(1);
          ACT_LINE_END: count <= '0;
          default:      count <= count;
        endcase
      end
      if (go && uw.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (in_fire) begin
      key <= scancode[SC_W-1] ? KEY_NONE : KEYMAP[scancode[SC_W-2:0]];
    end
    if (go && uw.emit) begin
      kind        <= uw.kind;
      char_value  <= ch_sel;
      line_length <= (uw.kind == KIND_END) ? LEN_W'(count) : '0;
      last        <= last_sel;
    end
  end

  sle_line_store #(
    .DEPTH (LINE_MAX),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (go && uw.act == ACT_STORE && can_store),
    .waddr (count[IDX_W-1:0]),
    .wdata (key),
    .raddr (ptr_next[IDX_W-1:0]),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

FILE: sv/sle_line_store.sv
// ----------------------------------------------------------------------------
// sle_line_store
// Line character memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_line_store #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [IDX_W-1:0]        waddr,
  input  wire logic [sle_pkg::CH_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]        raddr,
  output logic      [sle_pkg::CH_W-1:0] rdata
);
  import sle_pkg::*;

  logic [CH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the scancode line editor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [sle_pkg::KIND_W-1:0] kind,
  input wire logic [sle_pkg::CH_W-1:0]   char_value,
  input wire logic [sle_pkg::LEN_W-1:0]  line_length,
  input wire logic                       last
);
  import sle_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({kind, char_value, line_length, last}))
    else $error("stalled output beat changed");

  // line end closes the scancode's results
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END |-> last)
    else $error("line end without last");

  // a line character is never marked last and carries no length
  a_char_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CHAR |-> !last && line_length == '0)
    else $error("line character marked last or with length");

  // busy right after taking a scancode
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .char_value  (char_value),
  .line_length (line_length),
  .last        (last)
);

`default_nettype wire
